/* sv/tlc_pkg.sv */
// ----------------------------------------------------------------------------
// Tape language CPU package
// Shared widths, instruction characters, item kinds, error codes and the
// command/status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package tlc_pkg;

   // default sizes, handed down from the top level
   localparam int TAPE_CELLS_DEF    = 256;
   localparam int PROGRAM_DEPTH_DEF = 4096;

   // field widths
   localparam int KIND_W     = 2;
   localparam int BYTE_W     = 8;
   localparam int ERR_W      = 2;
   localparam int COUNT_W    = 13;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;
   localparam int RSP_USER_W = 1;

   // request kinds (the spare code is a no-op that just reports status)
   typedef enum logic [KIND_W-1:0] {
      KIND_CLEAR  = 2'd0,
      KIND_APPEND = 2'd1,
      KIND_STEP   = 2'd2,
      KIND_SPARE  = 2'd3
   } kind_type;

   // fault codes
   typedef enum logic [ERR_W-1:0] {
      ERR_NONE    = 2'd0,
      ERR_BRACKET = 2'd1,
      ERR_POINTER = 2'd2,
      ERR_FULL    = 2'd3
   } err_type;

   // instruction characters
   localparam logic [BYTE_W-1:0] OP_RIGHT = 8'h3E;  // '>'
   localparam logic [BYTE_W-1:0] OP_LEFT  = 8'h3C;  // '<'
   localparam logic [BYTE_W-1:0] OP_INC   = 8'h2B;  // '+'
   localparam logic [BYTE_W-1:0] OP_DEC   = 8'h2D;  // '-'
   localparam logic [BYTE_W-1:0] OP_READ  = 8'h2C;  // ','
   localparam logic [BYTE_W-1:0] OP_WRITE = 8'h2E;  // '.'
   localparam logic [BYTE_W-1:0] OP_OPEN  = 8'h5B;  // '['
   localparam logic [BYTE_W-1:0] OP_CLOSE = 8'h5D;  // ']'

   // controller -> datapath
   typedef struct packed {
      logic capture;   // latch request fields, clear step flags
      logic restart;   // clear request: reset length, counter, pointer, fault
      logic wipe;      // write zero to one tape cell, advance sweep
      logic append;    // append program byte
      logic exec;      // execute fetched instruction
      logic scan_rd;   // address program memory with scan pointer
      logic scan_chk;  // examine scanned byte
      logic load_out;  // load response register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      kind_type kind;
      logic     can_run;    // no fault and counter below program end
      logic     scan_go;    // executed bracket needs a scan
      logic     scan_done;  // scan found its match or ran out
      logic     wipe_last;  // sweep is at the last tape cell
   } sts_type;

endpackage

/* sv/tlc_ctrl.sv */
// ----------------------------------------------------------------------------
// Tape language CPU controller
// Sequences the clear sweep, append, fetch/execute and bracket scan, and
// owns the request ready and response valid handshake.
// ----------------------------------------------------------------------------
module tlc_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output tlc_pkg::cmd_type cmd,
   input  tlc_pkg::sts_type sts
);

   typedef enum logic [2:0] {
      ST_WIPE,
      ST_IDLE,
      ST_DECODE,
      ST_CLEAR,
      ST_EXEC,
      ST_SCAN_RD,
      ST_SCAN_CHK,
      ST_RESULT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   // next state and commands
   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      cmd          = '0;
      case (state_ff)
         ST_WIPE: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_DECODE;
            end
         end
         ST_DECODE: begin
            case (sts.kind)
               tlc_pkg::KIND_CLEAR: begin
                  cmd.restart = 1'b1;
                  state_in    = ST_CLEAR;
               end
               tlc_pkg::KIND_APPEND: begin
                  cmd.append = 1'b1;
                  state_in   = ST_RESULT;
               end
               tlc_pkg::KIND_STEP: begin
                  state_in = sts.can_run ? ST_EXEC : ST_RESULT;
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_CLEAR: begin
            cmd.wipe = 1'b1;
            if (sts.wipe_last) begin
               state_in = ST_RESULT;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = sts.scan_go ? ST_SCAN_RD : ST_RESULT;
         end
         ST_SCAN_RD: begin
            cmd.scan_rd = 1'b1;
            state_in    = ST_SCAN_CHK;
         end
         ST_SCAN_CHK: begin
            cmd.scan_chk = 1'b1;
            state_in     = sts.scan_done ? ST_RESULT : ST_SCAN_RD;
         end
         ST_RESULT: begin
            // wait for the response register to be free
            if (out_free) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_WIPE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* sv/tlc_dp.sv */
// ----------------------------------------------------------------------------
// Tape language CPU datapath
// Program memory, tape memory, program counter, data pointer, fault state,
// bracket scan pointer with nesting depth, and the response register.
// ----------------------------------------------------------------------------
module tlc_dp #(
   parameter int TAPE_CELLS    = tlc_pkg::TAPE_CELLS_DEF,
   parameter int PROGRAM_DEPTH = tlc_pkg::PROGRAM_DEPTH_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  tlc_pkg::cmd_type             cmd,
   output tlc_pkg::sts_type             sts,
   input  logic [tlc_pkg::KIND_W-1:0]   req_kind,
   input  logic [tlc_pkg::BYTE_W-1:0]   req_program_byte,
   input  logic [tlc_pkg::BYTE_W-1:0]   req_input_byte,
   output logic                         rsp_out_valid,
   output logic [tlc_pkg::BYTE_W-1:0]   rsp_out_byte,
   output logic                         rsp_used_input,
   output logic                         rsp_halted,
   output logic [tlc_pkg::ERR_W-1:0]    rsp_error_code,
   output logic [tlc_pkg::COUNT_W-1:0]  rsp_counter_now
);

   localparam int PW = $clog2(PROGRAM_DEPTH);
   localparam int LW = $clog2(PROGRAM_DEPTH + 1);
   localparam int TW = $clog2(TAPE_CELLS);
   localparam int BW = tlc_pkg::BYTE_W;
   localparam int CW = tlc_pkg::COUNT_W;
   localparam logic [TW-1:0] PTR_HOME = TW'((TAPE_CELLS - 1) / 2);
   localparam logic [TW-1:0] PTR_TOP  = TW'(TAPE_CELLS - 1);
   localparam logic [LW-1:0] LEN_MAX  = LW'(PROGRAM_DEPTH);

   // memories
   logic [BW-1:0] prog_mem [PROGRAM_DEPTH];
   logic [BW-1:0] tape_mem [TAPE_CELLS];
   logic [BW-1:0] prog_rd_ff;
   logic [BW-1:0] tape_rd_ff;

   // request fields
   tlc_pkg::kind_type kind_ff, kind_in;
   logic [BW-1:0]     ibyte_ff, ibyte_in;
   logic [BW-1:0]     pbyte_ff, pbyte_in;

   // machine state
   logic [LW-1:0]    len_ff, len_in;
   logic [LW-1:0]    pc_ff, pc_in;
   logic [TW-1:0]    ptr_ff, ptr_in;
   tlc_pkg::err_type fault_ff, fault_in;
   logic [TW-1:0]    wipe_ff, wipe_in;
   logic [LW-1:0]    scan_ff, scan_in;
   logic [LW-1:0]    depth_ff, depth_in;
   logic             fwd_ff, fwd_in;

   // per-step flags
   logic          ov_ff, ov_in;
   logic [BW-1:0] ob_ff, ob_in;
   logic          ui_ff, ui_in;

   // response register
   logic          out_valid_ff;
   logic [BW-1:0] out_byte_ff;
   logic          used_input_ff;
   logic          halted_ff;
   logic [tlc_pkg::ERR_W-1:0] error_ff;
   logic [CW-1:0] counter_ff;

   // memory ports
   logic          prog_we;
   logic [PW-1:0] prog_ra;
   logic          tape_we;
   logic [TW-1:0] tape_wa;
   logic [BW-1:0] tape_wd;

   // helpers
   logic          cell_zero;
   logic [LW-1:0] pc_next1;
   logic          fwd_room;
   logic          bwd_room;
   logic          jump_fwd;
   logic          jump_bwd;
   logic [LW-1:0] scan_next;
   logic          scan_more;
   logic [BW-1:0] close_b;
   logic [BW-1:0] open_b;
   logic          scan_hit;
   logic          halted_now;

   assign cell_zero  = (tape_rd_ff == '0);
   assign pc_next1   = pc_ff + LW'(1);
   assign fwd_room   = (pc_next1 < len_ff);
   assign bwd_room   = (pc_ff != '0);
   assign jump_fwd   = (prog_rd_ff == tlc_pkg::OP_OPEN) && cell_zero;
   assign jump_bwd   = (prog_rd_ff == tlc_pkg::OP_CLOSE) && !cell_zero;
   assign scan_next  = fwd_ff ? (scan_ff + LW'(1)) : (scan_ff - LW'(1));
   assign scan_more  = fwd_ff ? (scan_next < len_ff) : (scan_ff != '0);
   assign close_b    = fwd_ff ? tlc_pkg::OP_CLOSE : tlc_pkg::OP_OPEN;
   assign open_b     = fwd_ff ? tlc_pkg::OP_OPEN : tlc_pkg::OP_CLOSE;
   assign scan_hit   = (prog_rd_ff == close_b) && (depth_ff == LW'(1));
   assign halted_now = (fault_ff != tlc_pkg::ERR_NONE) || (pc_ff >= len_ff);
   assign prog_ra    = cmd.scan_rd ? scan_ff[PW-1:0] : pc_ff[PW-1:0];

   // status to the controller
   always_comb begin
      sts.kind      = kind_ff;
      sts.can_run   = (fault_ff == tlc_pkg::ERR_NONE) && (pc_ff < len_ff);
      sts.scan_go   = (jump_fwd && fwd_room) || (jump_bwd && bwd_room);
      sts.scan_done = scan_hit || !scan_more;
      sts.wipe_last = (wipe_ff == PTR_TOP);
   end

   // next state
   always_comb begin
      kind_in  = kind_ff;
      pbyte_in = pbyte_ff;
      ibyte_in = ibyte_ff;
      len_in   = len_ff;
      pc_in    = pc_ff;
      ptr_in   = ptr_ff;
      fault_in = fault_ff;
      wipe_in  = wipe_ff;
      scan_in  = scan_ff;
      depth_in = depth_ff;
      fwd_in   = fwd_ff;
      ov_in    = ov_ff;
      ob_in    = ob_ff;
      ui_in    = ui_ff;
      prog_we  = 1'b0;
      tape_we  = 1'b0;
      tape_wa  = ptr_ff;
      tape_wd  = tape_rd_ff;

      if (cmd.capture) begin
         kind_in  = tlc_pkg::kind_type'(req_kind);
         pbyte_in = req_program_byte;
         ibyte_in = req_input_byte;
         ov_in    = 1'b0;
         ob_in    = '0;
         ui_in    = 1'b0;
      end

      if (cmd.restart) begin
         len_in   = '0;
         pc_in    = '0;
         ptr_in   = PTR_HOME;
         fault_in = tlc_pkg::ERR_NONE;
      end

      // zero sweep over the tape
      if (cmd.wipe) begin
         tape_we = 1'b1;
         tape_wa = wipe_ff;
         tape_wd = '0;
         wipe_in = sts.wipe_last ? '0 : (wipe_ff + TW'(1));
      end

      if (cmd.append) begin
         if (len_ff < LEN_MAX) begin
            prog_we = 1'b1;
            len_in  = len_ff + LW'(1);
         end else if (fault_ff == tlc_pkg::ERR_NONE) begin
            fault_in = tlc_pkg::ERR_FULL;
         end
      end

      // one instruction
      if (cmd.exec) begin
         case (prog_rd_ff)
            tlc_pkg::OP_RIGHT: begin
               if (ptr_ff == PTR_TOP) begin
                  fault_in = tlc_pkg::ERR_POINTER;
               end else begin
                  ptr_in = ptr_ff + TW'(1);
                  pc_in  = pc_next1;
               end
            end
            tlc_pkg::OP_LEFT: begin
               if (ptr_ff == '0) begin
                  fault_in = tlc_pkg::ERR_POINTER;
               end else begin
                  ptr_in = ptr_ff - TW'(1);
                  pc_in  = pc_next1;
               end
            end
            tlc_pkg::OP_INC: begin
               tape_we = 1'b1;
               tape_wd = tape_rd_ff + BW'(1);
               pc_in   = pc_next1;
            end
            tlc_pkg::OP_DEC: begin
               tape_we = 1'b1;
               tape_wd = tape_rd_ff - BW'(1);
               pc_in   = pc_next1;
            end
            tlc_pkg::OP_READ: begin
               tape_we = 1'b1;
               tape_wd = ibyte_ff;
               ui_in   = 1'b1;
               pc_in   = pc_next1;
            end
            tlc_pkg::OP_WRITE: begin
               ov_in = 1'b1;
               ob_in = tape_rd_ff;
               pc_in = pc_next1;
            end
            tlc_pkg::OP_OPEN: begin
               if (!cell_zero) begin
                  pc_in = pc_next1;
               end else if (fwd_room) begin
                  scan_in  = pc_next1;
                  depth_in = LW'(1);
                  fwd_in   = 1'b1;
               end else begin
                  fault_in = tlc_pkg::ERR_BRACKET;
               end
            end
            tlc_pkg::OP_CLOSE: begin
               if (cell_zero) begin
                  pc_in = pc_next1;
               end else if (bwd_room) begin
                  scan_in  = pc_ff - LW'(1);
                  depth_in = LW'(1);
                  fwd_in   = 1'b0;
               end else begin
                  fault_in = tlc_pkg::ERR_BRACKET;
               end
            end
            default: begin
               pc_in = pc_next1;
            end
         endcase
      end

      // one scanned byte: track nesting, land after the match
      if (cmd.scan_chk) begin
         if (scan_hit) begin
            pc_in = scan_ff + LW'(1);
         end else if (!scan_more) begin
            fault_in = tlc_pkg::ERR_BRACKET;
         end else begin
            scan_in = scan_next;
            if (prog_rd_ff == close_b) begin
               depth_in = depth_ff - LW'(1);
            end else if (prog_rd_ff == open_b) begin
               depth_in = depth_ff + LW'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         pc_ff    <= '0;
         ptr_ff   <= PTR_HOME;
         fault_ff <= tlc_pkg::ERR_NONE;
         wipe_ff  <= '0;
      end else begin
         len_ff   <= len_in;
         pc_ff    <= pc_in;
         ptr_ff   <= ptr_in;
         fault_ff <= fault_in;
         wipe_ff  <= wipe_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      pbyte_ff <= pbyte_in;
      ibyte_ff <= ibyte_in;
      scan_ff  <= scan_in;
      depth_ff <= depth_in;
      fwd_ff   <= fwd_in;
      ov_ff    <= ov_in;
      ob_ff    <= ob_in;
      ui_ff    <= ui_in;
      if (cmd.load_out) begin
         out_valid_ff  <= ov_ff;
         out_byte_ff   <= ob_ff;
         used_input_ff <= ui_ff;
         halted_ff     <= halted_now;
         error_ff      <= fault_ff;
         counter_ff    <= CW'(pc_ff);
      end
   end

   // program memory: one write port, registered read
   always_ff @(posedge clock) begin
      if (prog_we) begin
         prog_mem[len_ff[PW-1:0]] <= pbyte_ff;
      end
      prog_rd_ff <= prog_mem[prog_ra];
   end

   // tape memory: one write port, registered read at the data pointer
   always_ff @(posedge clock) begin
      if (tape_we) begin
         tape_mem[tape_wa] <= tape_wd;
      end
      tape_rd_ff <= tape_mem[ptr_ff];
   end

   assign rsp_out_valid   = out_valid_ff;
   assign rsp_out_byte    = out_byte_ff;
   assign rsp_used_input  = used_input_ff;
   assign rsp_halted      = halted_ff;
   assign rsp_error_code  = error_ff;
   assign rsp_counter_now = counter_ff;

endmodule

/* sv/tape_language_cpu.sv */
// ----------------------------------------------------------------------------
// Tape language CPU
// Runs the eight-instruction tape language one instruction per step request.
// ----------------------------------------------------------------------------
// Every request gives exactly one response. The block works on one request
// at a time, stepped by a controller over program memory and tape memory
// (each one write port, registered read): an append or a step while halted
// goes through decode and response load, a plain instruction through fetch
// of program byte and tape cell, execute with tape write and response load,
// a taken bracket jump adds a read and a check per program byte scanned, and
// a clear adds the zero sweep over every tape cell. After reset the same
// sweep runs before the first request is taken. A finished response sits in
// an output register, so the next request is taken while it waits; a
// response only holds the block up if the previous one is still untaken
// when it is ready.
module tape_language_cpu #(
   parameter int TAPE_CELLS    = tlc_pkg::TAPE_CELLS_DEF,
   parameter int PROGRAM_DEPTH = tlc_pkg::PROGRAM_DEPTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // program_byte [7:0], input_byte [15:8]
   input  logic [tlc_pkg::REQ_DATA_W-1:0]    req_tdata,
   // kind [1:0]
   input  logic [tlc_pkg::KIND_W-1:0]        req_tuser,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // out_byte [7:0], used_input [8], halted [9], error_code [11:10],
   // counter_now [24:12], zero [31:25]
   output logic [tlc_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   // out_valid [0]
   output logic [tlc_pkg::RSP_USER_W-1:0]    rsp_tuser
);

   localparam int BW    = tlc_pkg::BYTE_W;
   localparam int PAD_W = tlc_pkg::RSP_DATA_W
                          - (BW + 2 + tlc_pkg::ERR_W + tlc_pkg::COUNT_W);

   tlc_pkg::cmd_type cmd;
   tlc_pkg::sts_type sts;

   logic                         out_valid;
   logic [BW-1:0]                out_byte;
   logic                         used_input;
   logic                         halted;
   logic [tlc_pkg::ERR_W-1:0]    error_code;
   logic [tlc_pkg::COUNT_W-1:0]  counter_now;

   tlc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd),
      .sts        (sts)
   );

   tlc_dp #(
      .TAPE_CELLS    (TAPE_CELLS),
      .PROGRAM_DEPTH (PROGRAM_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .req_kind         (req_tuser),
      .req_program_byte (req_tdata[BW-1:0]),
      .req_input_byte   (req_tdata[2*BW-1:BW]),
      .rsp_out_valid    (out_valid),
      .rsp_out_byte     (out_byte),
      .rsp_used_input   (used_input),
      .rsp_halted       (halted),
      .rsp_error_code   (error_code),
      .rsp_counter_now  (counter_now)
   );

   // response packing
   assign rsp_tdata = {PAD_W'(0), counter_now, error_code, halted, used_input, out_byte};
   assign rsp_tuser = out_valid;

endmodule
